// ----- hw/rtl/wirs_pkg.sv -----
package wirs_pkg;

   localparam int WORD_W  = 64;
   localparam int VALUE_W = 4 * WORD_W;
   localparam int TOP_W   = 4;
   localparam int COUNT_W = 3;
   localparam int DIGW_W  = 5;
   localparam int MODE_W  = 2;
   localparam int BIT_CNT_W = $clog2(VALUE_W);

   // radix mode codes
   localparam logic [MODE_W-1:0] RADIX_DEC = 2'd0;
   localparam logic [MODE_W-1:0] RADIX_HEX = 2'd1;
   localparam logic [MODE_W-1:0] RADIX_OCT = 2'd2;

   localparam logic [WORD_W-1:0] DEC_BASE = 64'd10000000000000000000;

   localparam logic [DIGW_W-1:0] DIGITS_DEC = 5'd19;
   localparam logic [DIGW_W-1:0] DIGITS_HEX = 5'd16;
   localparam logic [DIGW_W-1:0] DIGITS_OCT = 5'd21;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NEG,
      ST_SPLIT,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

// ----- hw/rtl/wirs_if.sv -----
interface wirs_req_if import wirs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] word0;
   logic [WORD_W-1:0] word1;
   logic [WORD_W-1:0] word2;
   logic [WORD_W-1:0] word3;

   modport source (output valid, word0, word1, word2, word3, input ready);
   modport sink (input valid, word0, word1, word2, word3, output ready);
endinterface

interface wirs_rsp_if import wirs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               negative;
   logic [WORD_W-1:0]  part0;
   logic [WORD_W-1:0]  part1;
   logic [WORD_W-1:0]  part2;
   logic [WORD_W-1:0]  part3;
   logic [TOP_W-1:0]   part4;
   logic [COUNT_W-1:0] part_count;
   logic [DIGW_W-1:0]  digits_per_part;

   modport source (output valid, negative, part0, part1, part2, part3, part4,
                   part_count, digits_per_part, input ready);
   modport sink (input valid, negative, part0, part1, part2, part3, part4,
                 part_count, digits_per_part, output ready);
endinterface

interface wirs_csr_if import wirs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] radix_mode;

   modport source (output valid, radix_mode, input ready);
   modport sink (input valid, radix_mode, output ready);
endinterface

// ----- hw/rtl/wide_int_radix_splitter_unit.sv -----
// channel    dir  beat
// req_chan   in   word0..word3, signed 256-bit value, word3[63] is the sign
// rsp_chan   out  negative, part0..part4, part_count, digits_per_part
// csr_chan   in   radix_mode: 0 decimal, 1 hex, 2 octal, 3 as decimal
//
// one item at a time. hex and octal run from request beat to response through
// the word-serial negate, the split step and the response register.
// decimal adds five bit-serial long divisions by 10^19, each paced by the
// single compare-subtract step.
// reset is synchronous and clears control state and radix_mode.
// a held response does not stall the next request beat; it waits at the end.
module wide_int_radix_splitter_unit import wirs_pkg::*; (
   input logic         clock,
   input logic         reset,
   wirs_req_if.sink    req_chan,
   wirs_rsp_if.source  rsp_chan,
   wirs_csr_if.sink    csr_chan
);

   // control state
   state_type               state_ff, state_in;
   logic [1:0]              word_cnt_ff, word_cnt_in;
   logic [BIT_CNT_W-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [2:0]              part_idx_ff, part_idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [MODE_W-1:0]       radix_mode_ff;

   // datapath
   logic [VALUE_W-1:0]      m_ff, m_in;
   logic                    carry_ff, carry_in;
   logic                    neg_ff, neg_in;
   logic [WORD_W-1:0]       rem_ff, rem_in;
   logic [WORD_W-1:0]       parts_ff [0:3];
   logic [WORD_W-1:0]       parts_in [0:3];
   logic [TOP_W-1:0]        part4_ff, part4_in;

   // response register
   logic                    rsp_negative_ff;
   logic [WORD_W-1:0]       rsp_part_ff [0:3];
   logic [TOP_W-1:0]        rsp_part4_ff;
   logic [COUNT_W-1:0]      rsp_count_ff;
   logic [DIGW_W-1:0]       rsp_digits_ff;
   logic                    rsp_load;

   // helpers
   logic [WORD_W-1:0]       neg_mask;
   logic [WORD_W:0]         neg_sum;
   logic [WORD_W:0]         div_trial;
   logic                    div_ge;
   logic [WORD_W-1:0]       div_rem;
   logic                    mode_hex, mode_oct;
   logic [COUNT_W-1:0]      part_count;
   logic [DIGW_W-1:0]       digits;

   assign mode_hex = (radix_mode_ff == RADIX_HEX);
   assign mode_oct = (radix_mode_ff == RADIX_OCT);

   // word-serial two's complement: low word in, top word out, carry rides along
   assign neg_mask = {WORD_W{neg_ff}};
   assign neg_sum  = {1'b0, m_ff[WORD_W-1:0] ^ neg_mask} + {{WORD_W{1'b0}}, carry_ff};

   // restoring division step: bring in top dividend bit, subtract base if it fits
   assign div_trial = {rem_ff, m_ff[VALUE_W-1]};
   assign div_ge    = (div_trial >= {1'b0, DEC_BASE});
   assign div_rem   = div_ge ? WORD_W'(div_trial - {1'b0, DEC_BASE})
                             : div_trial[WORD_W-1:0];

   // significant part count from the finished parts
   always_comb begin
      if (part4_ff != '0) begin
         part_count = 3'd5;
      end else if (parts_ff[3] != '0) begin
         part_count = 3'd4;
      end else if (parts_ff[2] != '0) begin
         part_count = 3'd3;
      end else if (parts_ff[1] != '0) begin
         part_count = 3'd2;
      end else begin
         part_count = 3'd1;
      end
   end

   always_comb begin
      if (mode_hex) begin
         digits = DIGITS_HEX;
      end else if (mode_oct) begin
         digits = DIGITS_OCT;
      end else begin
         digits = DIGITS_DEC;
      end
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;

   // next state and datapath
   always_comb begin
      state_in     = state_ff;
      word_cnt_in  = word_cnt_ff;
      bit_cnt_in   = bit_cnt_ff;
      part_idx_in  = part_idx_ff;
      m_in         = m_ff;
      carry_in     = carry_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      parts_in     = parts_ff;
      part4_in     = part4_ff;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               m_in        = {req_chan.word3, req_chan.word2, req_chan.word1,
                              req_chan.word0};
               neg_in      = req_chan.word3[WORD_W-1];
               carry_in    = req_chan.word3[WORD_W-1];
               word_cnt_in = '0;
               state_in    = ST_NEG;
            end
         end
         ST_NEG: begin
            // rotate right by one word, low word moved to the top, negated if the value is negative
            m_in        = {neg_sum[WORD_W-1:0], m_ff[VALUE_W-1:WORD_W]};
            carry_in    = neg_sum[WORD_W];
            word_cnt_in = word_cnt_ff + 2'd1;
            if (word_cnt_ff == 2'd3) begin
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            if (mode_hex) begin
               parts_in[0] = m_ff[63:0];
               parts_in[1] = m_ff[127:64];
               parts_in[2] = m_ff[191:128];
               parts_in[3] = m_ff[255:192];
               part4_in    = '0;
               state_in    = ST_DONE;
            end else if (mode_oct) begin
               parts_in[0] = {1'b0, m_ff[62:0]};
               parts_in[1] = {1'b0, m_ff[125:63]};
               parts_in[2] = {1'b0, m_ff[188:126]};
               parts_in[3] = {1'b0, m_ff[251:189]};
               part4_in    = m_ff[255:252];
               state_in    = ST_DONE;
            end else begin
               rem_in      = '0;
               bit_cnt_in  = '0;
               part_idx_in = '0;
               state_in    = ST_DIV;
            end
         end
         ST_DIV: begin
            m_in       = {m_ff[VALUE_W-2:0], div_ge};
            rem_in     = div_rem;
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == BIT_CNT_W'(VALUE_W - 1)) begin
               // one limb finished: quotient stays in m, remainder is the limb
               rem_in      = '0;
               part_idx_in = part_idx_ff + 3'd1;
               if (part_idx_ff == 3'd4) begin
                  part4_in = div_rem[TOP_W-1:0];
                  state_in = ST_DONE;
               end else begin
                  parts_in[part_idx_ff[1:0]] = div_rem;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_cnt_ff   <= '0;
         bit_cnt_ff    <= '0;
         part_idx_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         radix_mode_ff <= RADIX_DEC;
      end else begin
         word_cnt_ff  <= word_cnt_in;
         bit_cnt_ff   <= bit_cnt_in;
         part_idx_ff  <= part_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid) begin
            radix_mode_ff <= csr_chan.radix_mode;
         end
      end
   end

   always_ff @(posedge clock) begin
      m_ff     <= m_in;
      carry_ff <= carry_in;
      neg_ff   <= neg_in;
      rem_ff   <= rem_in;
      parts_ff <= parts_in;
      part4_ff <= part4_in;
      if (rsp_load) begin
         rsp_negative_ff <= neg_ff;
         rsp_part_ff     <= parts_ff;
         rsp_part4_ff    <= part4_ff;
         rsp_count_ff    <= part_count;
         rsp_digits_ff   <= digits;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.negative        = rsp_negative_ff;
   assign rsp_chan.part0           = rsp_part_ff[0];
   assign rsp_chan.part1           = rsp_part_ff[1];
   assign rsp_chan.part2           = rsp_part_ff[2];
   assign rsp_chan.part3           = rsp_part_ff[3];
   assign rsp_chan.part4           = rsp_part4_ff;
   assign rsp_chan.part_count      = rsp_count_ff;
   assign rsp_chan.digits_per_part = rsp_digits_ff;

endmodule
